// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL of the arm kinematics block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: src/tjik_pkg.sv
// ----------------------------------------------------------------------------
// tjik_pkg
// Types, widths, angle constants and the arctangent table of the arm block.
// ----------------------------------------------------------------------------
package tjik_pkg;
	localparam int CW = 50;
	localparam int AW = 26;
	localparam int CO_IN = 22;
	localparam int SQ_IN = 28;
	localparam int SQ_OUT = 22;
	localparam int FRAC = 16;
	localparam int DEF_ITERATIONS = 16;
	localparam logic [12:0] LINK_RESET = 13'd3712;

	localparam logic signed [AW-1:0] ANG_45 = AW'(45 * 65536);
	localparam logic signed [AW-1:0] ANG_90 = AW'(90 * 65536);
	localparam logic signed [AW-1:0] ANG_135 = AW'(135 * 65536);
	localparam logic signed [AW-1:0] ANG_225 = AW'(225 * 65536);

	typedef struct packed {
		logic        valid;
		logic [15:0] move_time;
		logic        origin;
		logic        reach_bad;
		logic        z_zero;
		logic        z_neg;
		logic        x_pos;
		logic        base_neg;
		logic        y_zero;
		logic        y_neg;
		logic [13:0] abs_x;
		logic [13:0] abs_y;
		logic [13:0] abs_z;
	} side_t;

	typedef struct packed {
		logic        valid;
		logic        bad;
		logic signed [AW-1:0] base;
		logic signed [AW-1:0] shoulder;
		logic signed [AW-1:0] elbow;
		logic [15:0] move_time;
	} res_t;

	typedef struct packed {
		logic [15:0] move_time_out;
		logic [8:0]  elbow_angle;
		logic [8:0]  shoulder_angle;
		logic [8:0]  base_angle;
		logic        valid_res;
	} out_t;

	function automatic logic [AW-1:0] atan_entry(input int i);
		logic [AW-1:0] v;
		case (i)
			0: v = AW'(2949120);
			1: v = AW'(1740967);
			2: v = AW'(919879);
			3: v = AW'(466945);
			4: v = AW'(234379);
			5: v = AW'(117304);
			6: v = AW'(58666);
			7: v = AW'(29335);
			8: v = AW'(14668);
			9: v = AW'(7334);
			10: v = AW'(3667);
			11: v = AW'(1833);
			12: v = AW'(917);
			13: v = AW'(458);
			14: v = AW'(229);
			15: v = AW'(115);
			16: v = AW'(57);
			17: v = AW'(29);
			18: v = AW'(14);
			19: v = AW'(7);
			20: v = AW'(4);
			21: v = AW'(2);
			22: v = AW'(1);
			default: v = '0;
		endcase
		return v;
	endfunction
endpackage

// File: src/tjik_isqrt.sv
// ----------------------------------------------------------------------------
// tjik_isqrt
// Pipelined floor square root of a value scaled by 2^16, one root bit a stage.
// ----------------------------------------------------------------------------
module tjik_isqrt (
	input  logic                        clk,
	input  logic                        en,
	input  logic [tjik_pkg::SQ_IN-1:0]  radicand,
	output logic [tjik_pkg::SQ_OUT-1:0] root
);
	import tjik_pkg::*;

	localparam int IW = SQ_IN + FRAC;
	localparam int RW = SQ_OUT + 3;

	logic [IW-1:0]     rad_s [0:SQ_OUT];
	logic [RW-1:0]     rem_s [0:SQ_OUT];
	logic [SQ_OUT-1:0] root_s [0:SQ_OUT];

	assign rad_s[0] = {radicand, FRAC'(0)};
	assign rem_s[0] = '0;
	assign root_s[0] = '0;

	for (genvar k = 0; k < SQ_OUT; k++) begin : g_stage
		logic [RW-1:0] shifted;
		logic [RW-1:0] trial;
		logic          take;

		always_comb begin
			shifted = {rem_s[k][RW-3:0], rad_s[k][IW-1 -: 2]};
			trial = {1'b0, root_s[k], 2'b01};
			take = shifted >= trial;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1] <= rad_s[k] << 2;
				rem_s[k+1] <= take ? shifted - trial : shifted;
				root_s[k+1] <= {root_s[k][SQ_OUT-2:0], take};
			end
		end
	end

	assign root = root_s[SQ_OUT];
endmodule

// File: src/tjik_cordic.sv
// ----------------------------------------------------------------------------
// tjik_cordic
// Pipelined vectoring CORDIC giving atan(ys/xs) in degrees, Q.16.
// ----------------------------------------------------------------------------
module tjik_cordic #(
	parameter int ITERATIONS = tjik_pkg::DEF_ITERATIONS
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic [tjik_pkg::CO_IN-1:0]        xs,
	input  logic [tjik_pkg::CO_IN-1:0]        ys,
	output logic signed [tjik_pkg::AW-1:0]    angle
);
	import tjik_pkg::*;

	localparam int PAD = CW - CO_IN - 24;

	logic signed [CW-1:0] cx_s [0:ITERATIONS];
	logic signed [CW-1:0] cy_s [0:ITERATIONS];
	logic signed [AW-1:0] ang_s [0:ITERATIONS];

	assign cx_s[0] = {PAD'(0), xs, 24'd0};
	assign cy_s[0] = {PAD'(0), ys, 24'd0};
	assign ang_s[0] = '0;

	for (genvar i = 0; i < ITERATIONS; i++) begin : g_stage
		localparam logic signed [AW-1:0] STEP = $signed(atan_entry(i));
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;

		always_comb begin
			dx = cx_s[i] >>> i;
			dy = cy_s[i] >>> i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!cy_s[i][CW-1]) begin
					cx_s[i+1] <= cx_s[i] + dy;
					cy_s[i+1] <= cy_s[i] - dx;
					ang_s[i+1] <= ang_s[i] + STEP;
				end else begin
					cx_s[i+1] <= cx_s[i] - dy;
					cy_s[i+1] <= cy_s[i] + dx;
					ang_s[i+1] <= ang_s[i] - STEP;
				end
			end
		end
	end

	assign angle = ang_s[ITERATIONS];
endmodule

// File: src/three_joint_arm_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// three_joint_arm_inverse_kinematics
// Joint angles of a yaw base and two equal planar links for a target point.
// ----------------------------------------------------------------------------
// One target is taken per cycle while s_tready is high, and each gives one
// result transfer. Its path is a register of squares, a register of sums,
// 22 pipelined square root stages of one root bit each, one stage per CORDIC
// iteration for the three arctangents, a register of angle sums and the
// output buffer.
// A two-entry output buffer lets inputs keep flowing while a result waits;
// the pipeline holds only when it is full. Unreachable targets, the origin
// and negative base angles give a result with valid_res low and all angles
// zero.
`include "assert_macros.svh"

module three_joint_arm_inverse_kinematics #(
	parameter int CORDIC_ITERATIONS = tjik_pkg::DEF_ITERATIONS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [12:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// target_x, target_y, target_z, move_time, zero pad
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// valid_res, base_angle, shoulder_angle, elbow_angle, move_time_out, zero pad
	output logic [47:0] m_tdata
);
	import tjik_pkg::*;

	logic [12:0] link_length_q;
	logic        en;
	logic [1:0]  cnt_q;
	out_t        head_q, tail_q, beat;
	logic        push, pop;

	logic               valid_s1;
	logic signed [13:0] x_s1, y_s1, z_s1;
	logic [15:0]        mt_s1;
	logic [26:0]        xx_s1, yy_s1, zz_s1;
	logic [25:0]        ll_s1;

	side_t            side_s2;
	logic [SQ_IN-1:0] dxz_s2, r2_s2, diff_s2;
	logic [SQ_IN-1:0] dxz, r2, l4;

	side_t             sb_sq_s [0:SQ_OUT];
	side_t             sb_co_s [0:CORDIC_ITERATIONS];
	logic [SQ_OUT-1:0] d_root, r_root, s_root;
	logic signed [AW-1:0] ang_base, ang_acos, ang_elev;
	side_t             sb;
	logic signed [AW-1:0] b_atan, b_sum, elev;
	res_t              res_s3;

	function automatic logic [8:0] trunc_deg(input logic signed [AW-1:0] v);
		logic [AW-1:0] mag;
		logic [8:0]    t;
		mag = v[AW-1] ? AW'(-v) : AW'(v);
		t = mag[FRAC +: 9];
		return v[AW-1] ? 9'(-t) : t;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_length_q <= LINK_RESET;
		end else if (cfg_wen) begin
			link_length_q <= cfg_wdata;
		end
	end

	assign en = cnt_q != 2'd2;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= $signed(s_tdata[13:0]);
			y_s1 <= $signed(s_tdata[27:14]);
			z_s1 <= $signed(s_tdata[41:28]);
			mt_s1 <= s_tdata[57:42];
			xx_s1 <= 27'($signed(s_tdata[13:0]) * $signed(s_tdata[13:0]));
			yy_s1 <= 27'($signed(s_tdata[27:14]) * $signed(s_tdata[27:14]));
			zz_s1 <= 27'($signed(s_tdata[41:28]) * $signed(s_tdata[41:28]));
			ll_s1 <= 26'(link_length_q * link_length_q);
		end
	end

	always_comb begin
		dxz = SQ_IN'(xx_s1) + SQ_IN'(zz_s1);
		r2 = dxz + SQ_IN'(yy_s1);
		l4 = {ll_s1, 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2.valid <= 1'b0;
		end else if (en) begin
			side_s2.valid <= valid_s1;
			side_s2.move_time <= mt_s1;
			side_s2.origin <= (x_s1 == '0) && (z_s1 == '0);
			side_s2.reach_bad <= r2 > l4;
			side_s2.z_zero <= z_s1 == '0;
			side_s2.z_neg <= z_s1[13];
			side_s2.x_pos <= !x_s1[13];
			side_s2.base_neg <= (x_s1 != '0) && (x_s1[13] ^ z_s1[13]);
			side_s2.y_zero <= y_s1 == '0;
			side_s2.y_neg <= y_s1[13];
			side_s2.abs_x <= x_s1[13] ? 14'(-x_s1) : 14'(x_s1);
			side_s2.abs_y <= y_s1[13] ? 14'(-y_s1) : 14'(y_s1);
			side_s2.abs_z <= z_s1[13] ? 14'(-z_s1) : 14'(z_s1);
			dxz_s2 <= dxz;
			r2_s2 <= r2;
			diff_s2 <= l4 - r2;
		end
	end

	tjik_isqrt u_sqrt_d (
		.clk(clk), .en(en), .radicand(dxz_s2), .root(d_root)
	);
	tjik_isqrt u_sqrt_r (
		.clk(clk), .en(en), .radicand(r2_s2), .root(r_root)
	);
	tjik_isqrt u_sqrt_s (
		.clk(clk), .en(en), .radicand(diff_s2), .root(s_root)
	);

	assign sb_sq_s[0] = side_s2;
	for (genvar k = 0; k < SQ_OUT; k++) begin : g_sq_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sb_sq_s[k+1].valid <= 1'b0;
			end else if (en) begin
				sb_sq_s[k+1] <= sb_sq_s[k];
			end
		end
	end

	tjik_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_base (
		.clk(clk), .en(en),
		.xs({8'd0, sb_sq_s[SQ_OUT].abs_z}),
		.ys({8'd0, sb_sq_s[SQ_OUT].abs_x}),
		.angle(ang_base)
	);
	tjik_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_acos (
		.clk(clk), .en(en),
		.xs(r_root), .ys(s_root), .angle(ang_acos)
	);
	tjik_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_elev (
		.clk(clk), .en(en),
		.xs({sb_sq_s[SQ_OUT].abs_y, 8'd0}), .ys(d_root), .angle(ang_elev)
	);

	assign sb_co_s[0] = sb_sq_s[SQ_OUT];
	for (genvar k = 0; k < CORDIC_ITERATIONS; k++) begin : g_co_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sb_co_s[k+1].valid <= 1'b0;
			end else if (en) begin
				sb_co_s[k+1] <= sb_co_s[k];
			end
		end
	end

	always_comb begin
		sb = sb_co_s[CORDIC_ITERATIONS];
		if (sb.z_zero) begin
			b_atan = sb.x_pos ? ANG_90 : -ANG_90;
		end else begin
			b_atan = sb.base_neg ? -ang_base : ang_base;
		end
		b_sum = b_atan + (sb.z_neg ? ANG_225 : ANG_45);
		if (sb.y_zero) begin
			elev = ANG_90;
		end else begin
			elev = sb.y_neg ? -ang_elev : ang_elev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s3.valid <= 1'b0;
		end else if (en) begin
			res_s3.valid <= sb.valid;
			res_s3.bad <= sb.origin || sb.reach_bad || b_sum[AW-1];
			res_s3.base <= b_sum;
			res_s3.shoulder <= ANG_135 - ang_acos + elev;
			res_s3.elbow <= ANG_135 + (ang_acos <<< 1);
			res_s3.move_time <= sb.move_time;
		end
	end

	always_comb begin
		beat.valid_res = !res_s3.bad;
		beat.base_angle = res_s3.bad ? '0 : trunc_deg(res_s3.base);
		beat.shoulder_angle = res_s3.bad ? '0 : trunc_deg(res_s3.shoulder);
		beat.elbow_angle = res_s3.bad ? '0 : trunc_deg(res_s3.elbow);
		beat.move_time_out = res_s3.move_time;
	end

	assign push = en && res_s3.valid;
	assign pop = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					head_q <= beat;
				end else begin
					tail_q <= beat;
				end
			end
			2'b01: head_q <= tail_q;
			2'b11: begin
				if (cnt_q == 2'd1) begin
					head_q <= beat;
				end else begin
					head_q <= tail_q;
					tail_q <= beat;
				end
			end
			default: head_q <= head_q;
		endcase
	end

	assign m_tvalid = cnt_q != 2'd0;
	assign m_tdata = {4'd0, head_q};

	`ASSERT_IMPL(a_cnt_range, clk, arst_n, 1'b1, cnt_q != 2'd3)
	`ASSERT_IMPL(a_bad_zero, clk, arst_n, m_tvalid && !m_tdata[0], m_tdata[27:1] == 27'd0)
	`ASSERT_IMPL(a_good_range, clk, arst_n, m_tvalid && m_tdata[0],
		m_tdata[27:19] >= 9'd134 && m_tdata[9:1] <= 9'd315)
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, !en && res_s3.valid, res_s3.valid)
endmodule
